>>> hw/rtl/cves_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cves_pkg: shared types and constants of the cell value encoder
// Holds status codes, register indexes and the double constants used when a
// cell saturates.
// ----------------------------------------------------------------------------
package cves_pkg;

   localparam int unsigned ValueWidth  = 64;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDatWidth = 4;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CLAMPED   = 2'd1,
      STATUS_NONFINITE = 2'd2
   } status_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CELL_WIDTH = 3'd0,
      CSR_SIGNED     = 3'd1,
      CSR_FLOAT      = 3'd2,
      CSR_BIG_ENDIAN = 3'd3
   } csr_index_type;

   // Magnitude of the largest finite single, as double bits without sign.
   localparam logic [62:0] SingleMaxDbl = 63'h47EF_FFFF_E000_0000;
   localparam logic [30:0] SingleMaxSgl = 31'h7F7F_FFFF;

   // Double value of 2^k - 1 for k in 1..64, rounded to nearest even.
   function automatic logic [63:0] pow2m1_dbl(input logic [6:0] k);
      logic [63:0] ones;
      logic [63:0] mant;
      logic [10:0] expo;
      ones = 64'd0;
      mant = 64'd0;
      expo = 11'd0;
      if (k >= 7'd54) begin
         expo = 11'd1023 + {4'd0, k};
      end else begin
         expo = 11'd1022 + {4'd0, k};
         ones = (64'd1 << (k - 7'd1)) - 64'd1;
         mant = ones << (7'd53 - k);
      end
      pow2m1_dbl = {1'b0, expo, mant[51:0]};
   endfunction

endpackage

>>> hw/rtl/cell_value_encode_saturating.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_value_encode_saturating: double to memory cell encoder
// Packs one IEEE double into an integer or float cell of 1 to 8 bytes with
// saturation, rounding and the configured byte order.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                        Direction  Handshake
//  request   start, busy, req_value_in    in         start high, busy low
//  response  rsp_valid, rsp_*             out        one-cycle strobe
//  config    csr_write_enable/index/wdata in         write enable high
//
// A request is taken in any cycle; busy is always low. Its response passes
// through the input register, then the conversion logic settles into the
// result register. One request per cycle is sustained. Reset clears the
// valid flags and signed, float and byte order, and sets the width to one
// byte. The receiver cannot stall, so nothing is ever held back.
//
module cell_value_encode_saturating (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cves_pkg::ValueWidth-1:0] req_value_in,
   output logic                            rsp_valid,
   output logic [cves_pkg::ValueWidth-1:0] rsp_cell_bytes,
   output logic [cves_pkg::ValueWidth-1:0] rsp_cell_bits,
   output logic [cves_pkg::ValueWidth-1:0] rsp_stored_value,
   output logic [cves_pkg::StatusWidth-1:0] rsp_status,
   input  logic                             csr_write_enable,
   input  logic [cves_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [cves_pkg::CsrDatWidth-1:0] csr_wdata
);

   // Configuration registers.
   logic [3:0] width_ff;
   logic       signed_ff;
   logic       float_ff;
   logic       big_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 4'd1;
         signed_ff <= 1'b0;
         float_ff  <= 1'b0;
         big_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (cves_pkg::csr_index_type'(csr_index))
            cves_pkg::CSR_CELL_WIDTH: width_ff  <= csr_wdata;
            cves_pkg::CSR_SIGNED:     signed_ff <= csr_wdata[0];
            cves_pkg::CSR_FLOAT:      float_ff  <= csr_wdata[0];
            cves_pkg::CSR_BIG_ENDIAN: big_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register.
   logic        in_valid_ff;
   logic [63:0] in_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         in_value_ff <= req_value_in;
      end
   end

   assign busy = 1'b0;

   // Conversion logic between the input and result registers.
   logic [63:0] bytes_in;
   logic [63:0] bits_in;
   logic [63:0] stored_in;
   cves_pkg::status_type status_in;

   logic        s;
   logic [10:0] e;
   logic [51:0] m;
   logic [52:0] sig;
   logic [3:0]  wc;
   logic [6:0]  nb;
   logic [6:0]  nbm1;
   // integer path
   logic        big;
   logic [63:0] mag;
   logic [53:0] rtmp;
   logic [5:0]  rsh;
   logic        half_hit;
   logic        half_eq;
   logic        full_hit;
   logic        iclamp;
   logic [63:0] ival;
   logic [63:0] half_val;
   logic [63:0] umask;
   logic [63:0] iround;
   logic [62:0] mag_bits;
   logic [62:0] rinc;
   logic [62:0] rmask;
   logic [5:0]  fsh;
   // float path
   logic        fclamp;
   logic [5:0]  ssh;
   logic [11:0] ssh_wide;
   logic [7:0]  expf;
   logic [116:0] fext;
   logic        rup;
   logic [30:0] fmag;
   logic [31:0] f32;
   logic [63:0] fdbl;
   logic [4:0]  lead;
   logic [51:0] sub_mant;
   // byte ordering
   logic [2:0]  src;

   always_comb begin
      s   = in_value_ff[63];
      e   = in_value_ff[62:52];
      m   = in_value_ff[51:0];
      sig = {(e != 11'd0), m};
      wc  = (width_ff == 4'd0) ? 4'd1 : ((width_ff > 4'd8) ? 4'd8 : width_ff);
      nb  = {wc, 3'b000};
      nbm1 = nb - 7'd1;

      // Integer magnitude rounded half away from zero.
      big  = (e >= 11'd1087);
      rsh  = 6'd0;
      rtmp = 54'd0;
      mag  = 64'd0;
      if (e < 11'd1022) begin
         mag = 64'd0;
      end else if (e < 11'd1075) begin
         rsh  = 6'(11'd1075 - e);
         rtmp = {sig, 1'b0} >> rsh;
         mag  = {11'd0, rtmp[53:1]} + {63'd0, rtmp[0]};
      end else if (!big) begin
         mag = {11'd0, sig} << (e - 11'd1075);
      end
      half_val = 64'd1 << nbm1;
      half_hit = |(mag >> nbm1);
      half_eq  = (mag == half_val);
      full_hit = |(mag >> nb);
      umask    = {64{1'b1}} >> (7'd64 - nb);

      // Double of the rounded value when nothing saturates.
      mag_bits = {e, m};
      fsh   = 6'd0;
      rinc  = 63'd0;
      rmask = 63'd0;
      if (e < 11'd1022) begin
         iround = 64'd0;
      end else if (e == 11'd1022) begin
         iround = {s, 63'h3FF0_0000_0000_0000};
      end else if (e < 11'd1075) begin
         fsh    = 6'(11'd1075 - e);
         rinc   = 63'd1 << (fsh - 6'd1);
         rmask  = ~((63'd1 << fsh) - 63'd1);
         iround = {s, (mag_bits + rinc) & rmask};
      end else begin
         iround = in_value_ff;
      end

      if (signed_ff) begin
         if (s) begin
            iclamp = big | (half_hit & !half_eq);
            ival   = iclamp ? (64'd0 - half_val) : (64'd0 - mag);
         end else begin
            iclamp = big | half_hit;
            ival   = iclamp ? (half_val - 64'd1) : mag;
         end
      end else begin
         if (s & (big | (mag != 64'd0))) begin
            iclamp = 1'b1;
            ival   = 64'd0;
         end else if (big | full_hit) begin
            iclamp = 1'b1;
            ival   = umask;
         end else begin
            iclamp = 1'b0;
            ival   = mag;
         end
      end

      // Single precision narrowing with round to nearest even.
      fclamp = (mag_bits > cves_pkg::SingleMaxDbl);
      ssh_wide = 12'd0;
      if (e >= 11'd897) begin
         ssh  = 6'd29;
         expf = 8'(e - 11'd896);
      end else begin
         ssh_wide = 12'd926 - {1'b0, e};
         ssh  = (ssh_wide > 12'd63) ? 6'd63 : ssh_wide[5:0];
         expf = 8'd0;
      end
      fext = {sig, 64'd0} >> ssh;
      rup  = fext[63] & ((|fext[62:0]) | fext[64]);
      fmag = {expf, fext[86:64]} + {30'd0, rup};
      if (fclamp) begin
         f32 = {s, cves_pkg::SingleMaxSgl};
      end else begin
         f32 = {s, fmag};
      end

      // Widen the single back to a double.
      lead = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (f32[i]) begin
            lead = 5'(i);
         end
      end
      sub_mant = {29'd0, f32[22:0]} << (6'd52 - {1'b0, lead});
      if (f32[30:23] != 8'd0) begin
         fdbl = {f32[31], {3'd0, f32[30:23]} + 11'd896, f32[22:0], 29'd0};
      end else if (f32[22:0] != 23'd0) begin
         fdbl = {f32[31], {6'd0, lead} + 11'd874, sub_mant};
      end else begin
         fdbl = {f32[31], 63'd0};
      end

      // Select the cell kind.
      status_in = cves_pkg::STATUS_OK;
      if (float_ff) begin
         if (wc == 4'd4) begin
            bits_in   = {32'd0, f32};
            stored_in = fdbl;
            if (fclamp) begin
               status_in = cves_pkg::STATUS_CLAMPED;
            end
         end else begin
            bits_in   = in_value_ff;
            stored_in = in_value_ff;
         end
      end else begin
         bits_in = ival;
         if (iclamp) begin
            status_in = cves_pkg::STATUS_CLAMPED;
            if (signed_ff) begin
               stored_in = s ? {1'b1, 11'd1022 + {4'd0, nb}, 52'd0}
                             : cves_pkg::pow2m1_dbl(nbm1);
            end else begin
               stored_in = s ? 64'd0 : cves_pkg::pow2m1_dbl(nb);
            end
         end else begin
            stored_in = iround;
         end
      end

      // Byte ordering; bytes past the width read as zero.
      bytes_in = 64'd0;
      src      = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < wc) begin
            src = big_ff ? 3'(wc - 4'd1 - 4'(i)) : 3'(i);
            bytes_in[i*8 +: 8] = bits_in[src*8 +: 8];
         end
      end

      // A non-finite input overrides everything.
      if (e == 11'h7FF) begin
         bytes_in  = 64'd0;
         bits_in   = 64'd0;
         stored_in = in_value_ff;
         status_in = cves_pkg::STATUS_NONFINITE;
      end
   end

   // Result register.
   logic        rsp_valid_ff;
   logic [63:0] bytes_ff;
   logic [63:0] bits_ff;
   logic [63:0] stored_ff;
   cves_pkg::status_type status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         bytes_ff  <= bytes_in;
         bits_ff   <= bits_in;
         stored_ff <= stored_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_bytes   = bytes_ff;
   assign rsp_cell_bits    = bits_ff;
   assign rsp_stored_value = stored_ff;
   assign rsp_status       = status_ff;

   // Every response traces back to an earlier request.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("response without a request");

   // A non-finite response carries empty cell bytes and bits.
   a_nonfinite_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cves_pkg::STATUS_NONFINITE) |->
         (rsp_cell_bits == 64'd0 && rsp_cell_bytes == 64'd0))
      else $error("non-finite response with cell data");

   // A non-finite response echoes the request value.
   a_nonfinite_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cves_pkg::STATUS_NONFINITE) |->
         rsp_stored_value == $past(req_value_in, 2))
      else $error("non-finite response does not echo the value");

endmodule

>>> tb/cell_value_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_value_checker: response checker for the cell value encoder
// Follows the configuration port, predicts every accepted request with a
// bit-exact integer model of the conversion and compares the responses.
// ----------------------------------------------------------------------------
module cell_value_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [cves_pkg::ValueWidth-1:0]  req_value_in,
   input  logic                             rsp_valid,
   input  logic [cves_pkg::ValueWidth-1:0]  rsp_cell_bytes,
   input  logic [cves_pkg::ValueWidth-1:0]  rsp_cell_bits,
   input  logic [cves_pkg::ValueWidth-1:0]  rsp_stored_value,
   input  logic [cves_pkg::StatusWidth-1:0] rsp_status,
   input  logic                             csr_write_enable,
   input  logic [cves_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [cves_pkg::CsrDatWidth-1:0] csr_wdata,
   output int                               mismatch_count,
   output int                               cells_waiting,
   output int                               cells_checked
);

   typedef struct packed {
      logic [63:0]          cell_bytes;
      logic [63:0]          cell_bits;
      logic [63:0]          stored_value;
      cves_pkg::status_type status;
   } cell_type;

   logic [3:0] width_ff;
   logic       signed_ff;
   logic       float_ff;
   logic       big_endian_ff;
   cell_type   expected_cells[$];

   // Integer magnitude to double, round to nearest even.
   function automatic logic [63:0] int_to_double(input logic neg, input logic [63:0] mag);
      int          msb;
      int          sh;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] hb;
      msb = 0;
      if (mag == 64'd0) return 64'd0;
      for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
      if (msb <= 52) begin
         q = mag << (52 - msb);
      end else begin
         sh = msb - 52;
         q = mag >> sh;
         rem = mag & ((64'd1 << sh) - 64'd1);
         hb = 64'd1 << (sh - 1);
         if (rem > hb || (rem == hb && q[0])) q = q + 64'd1;
         if (q[53]) begin
            q = q >> 1;
            msb = msb + 1;
         end
      end
      return {neg, 11'(1023 + msb), q[51:0]};
   endfunction

   function automatic cell_type encode_cell(input logic [63:0] v);
      cell_type     r;
      int           w;
      int           n;
      int           e;
      int           se;
      int           expo;
      int           sh;
      int           msb;
      logic         s;
      logic         neg;
      logic         big;
      logic [62:0]  mag63;
      logic [63:0]  sig;
      logic [63:0]  q;
      logic [63:0]  rem;
      logic [63:0]  hb;
      logic [63:0]  body;
      logic [63:0]  bits;
      logic [31:0]  sgl;
      logic [127:0] mag;
      logic [127:0] half;
      r = '0;
      r.status = cves_pkg::STATUS_OK;
      if (v[62:52] == 11'h7ff) begin
         r.stored_value = v;
         r.status = cves_pkg::STATUS_NONFINITE;
         return r;
      end
      w = (width_ff == 4'd0) ? 1 : (width_ff > 4'd8) ? 8 : int'(width_ff);
      n = w * 8;
      s = v[63];
      bits = 64'd0;
      if (float_ff && w == 4) begin
         mag63 = v[62:0];
         if (mag63 > cves_pkg::SingleMaxDbl) begin
            mag63 = cves_pkg::SingleMaxDbl;
            r.status = cves_pkg::STATUS_CLAMPED;
         end
         e = int'(mag63[62:52]);
         if (e == 0) begin
            sgl = {s, 31'd0};
         end else begin
            sig = {11'd0, 1'b1, mag63[51:0]};
            se = e - 896;
            sh = (se >= 1) ? 29 : 30 - se;
            if (sh > 63) sh = 63;
            q = sig >> sh;
            rem = sig & ((64'd1 << sh) - 64'd1);
            hb = 64'd1 << (sh - 1);
            if (rem > hb || (rem == hb && q[0])) q = q + 64'd1;
            body = (se >= 1) ? ((64'(se) << 23) + q - 64'h80_0000) : q;
            sgl = {s, body[30:0]};
         end
         bits = {32'd0, sgl};
         // Widen the single back to double: always exact.
         if (sgl[30:23] != 8'd0) begin
            r.stored_value = {s, 11'(int'(sgl[30:23]) + 896), sgl[22:0], 29'd0};
         end else if (sgl[22:0] == 23'd0) begin
            r.stored_value = {s, 63'd0};
         end else begin
            msb = 0;
            for (int i = 0; i < 23; i++) if (sgl[i]) msb = i;
            q = 64'(sgl[22:0]) << (52 - msb);
            r.stored_value = {s, 11'(msb + 874), q[51:0]};
         end
      end else if (float_ff) begin
         bits = v;
         r.stored_value = v;
      end else begin
         e = int'(v[62:52]);
         sig = (e == 0) ? {12'd0, v[51:0]} : {11'd0, 1'b1, v[51:0]};
         expo = (e == 0) ? -1074 : e - 1075;
         big = 1'b0;
         mag = '0;
         if (expo > 64) begin
            big = 1'b1;
         end else if (expo >= 0) begin
            mag = 128'(sig) << expo;
         end else if (-expo < 60) begin
            mag = 128'(sig >> (-expo));
            if (sig[-expo - 1]) mag = mag + 128'd1;
         end
         neg = s && (big || mag != 0);
         half = 128'd1 << (n - 1);
         if (signed_ff) begin
            if (neg && (big || mag > half)) begin
               bits = -half[63:0];
               r.stored_value = int_to_double(1'b1, half[63:0]);
               r.status = cves_pkg::STATUS_CLAMPED;
            end else if (!neg && (big || mag >= half)) begin
               bits = half[63:0] - 64'd1;
               r.stored_value = int_to_double(1'b0, bits);
               r.status = cves_pkg::STATUS_CLAMPED;
            end else begin
               bits = neg ? -mag[63:0] : mag[63:0];
               r.stored_value = int_to_double(neg, mag[63:0]);
            end
         end else begin
            if (neg) begin
               bits = 64'd0;
               r.status = cves_pkg::STATUS_CLAMPED;
            end else if (big || mag >= (half << 1)) begin
               bits = 64'(((half << 1) - 128'd1));
               r.status = cves_pkg::STATUS_CLAMPED;
            end else begin
               bits = mag[63:0];
            end
            r.stored_value = int_to_double(1'b0, bits);
         end
      end
      r.cell_bits = bits;
      for (int i = 0; i < w; i++)
         r.cell_bytes[i*8 +: 8] = bits[(big_endian_ff ? (w - 1 - i) : i) * 8 +: 8];
      return r;
   endfunction

   always_ff @(posedge clock) begin
      cell_type got;
      cell_type want;
      if (reset) begin
         width_ff <= 4'd1;
         signed_ff <= 1'b0;
         float_ff <= 1'b0;
         big_endian_ff <= 1'b0;
         mismatch_count <= 0;
         cells_checked <= 0;
         expected_cells.delete();
      end else begin
         if (rsp_valid) begin
            got = {rsp_cell_bytes, rsp_cell_bits, rsp_stored_value,
                   cves_pkg::status_type'(rsp_status)};
            if (expected_cells.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_cells.pop_front();
               cells_checked <= cells_checked + 1;
               if (got != want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (got.cell_bytes != want.cell_bytes)
                     $error("cell_bytes expected %h actual %h", want.cell_bytes, got.cell_bytes);
                  if (got.cell_bits != want.cell_bits)
                     $error("cell_bits expected %h actual %h", want.cell_bits, got.cell_bits);
                  if (got.stored_value != want.stored_value)
                     $error("stored_value expected %h actual %h",
                            want.stored_value, got.stored_value);
                  if (got.status != want.status)
                     $error("status expected %0d actual %0d", want.status, got.status);
               end
            end
         end
         if (start && !busy) expected_cells.push_back(encode_cell(req_value_in));
         if (csr_write_enable) begin
            case (csr_index)
               cves_pkg::CSR_CELL_WIDTH: width_ff <= csr_wdata;
               cves_pkg::CSR_SIGNED:     signed_ff <= csr_wdata[0];
               cves_pkg::CSR_FLOAT:      float_ff <= csr_wdata[0];
               cves_pkg::CSR_BIG_ENDIAN: big_endian_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   assign cells_waiting = expected_cells.size();

endmodule

>>> tb/cell_value_encode_saturating_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_value_encode_saturating_tb: top level test of the cell value encoder
// Drives directed and random doubles through a series of cell settings,
// leaves the checking to cell_value_checker and reports the verdict.
// ----------------------------------------------------------------------------
module cell_value_encode_saturating_tb;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [cves_pkg::ValueWidth-1:0]  req_value_in;
   logic                             rsp_valid;
   logic [cves_pkg::ValueWidth-1:0]  rsp_cell_bytes;
   logic [cves_pkg::ValueWidth-1:0]  rsp_cell_bits;
   logic [cves_pkg::ValueWidth-1:0]  rsp_stored_value;
   logic [cves_pkg::StatusWidth-1:0] rsp_status;
   logic                             csr_write_enable;
   logic [cves_pkg::CsrIdxWidth-1:0] csr_index;
   logic [cves_pkg::CsrDatWidth-1:0] csr_wdata;
   int                               mismatch_count;
   int                               cells_waiting;
   int                               cells_checked;
   int                               request_count;
   int                               setting_count;

   cell_value_encode_saturating DUT (.*);

   cell_value_checker checker_inst (.*);

   // Free running clock with a 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("cell_value_encode_saturating_tb NOT OK");
      $finish;
   end

   // One register write. The enable is raised at one edge and lowered at the
   // next, so back-to-back calls never assign it twice in the same step.
   task automatic write_reg(input logic [cves_pkg::CsrIdxWidth-1:0] idx,
                            input logic [3:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Reconfigure the cell. The block must be quiet first: no new request,
   // every response in and its two-stage pipeline empty.
   task automatic set_cell(input logic [3:0] width, input logic sgn, input logic flt,
                           input logic be);
      start <= 1'b0;
      wait (cells_waiting == 0);
      repeat (4) @(posedge clock);
      write_reg(cves_pkg::CSR_CELL_WIDTH, width);
      write_reg(cves_pkg::CSR_SIGNED, {3'd0, sgn});
      write_reg(cves_pkg::CSR_FLOAT, {3'd0, flt});
      write_reg(cves_pkg::CSR_BIG_ENDIAN, {3'd0, be});
      // Indexes past the last register must be ignored; poke one now and then.
      if ($urandom_range(0, 1))
         write_reg(cves_pkg::CsrIdxWidth'(cves_pkg::CSR_BIG_ENDIAN)
                   + cves_pkg::CsrIdxWidth'($urandom_range(1, 4)),
                   4'($urandom));
      setting_count++;
   endtask

   // Present one request and hold it until it is taken. The caller is right
   // after a rising edge; on return we are right after the accepting edge.
   task automatic send_value(input logic [63:0] v, input bit allow_idle);
      bit taken;
      if (allow_idle) begin
         while ($urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_value_in <= v;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      request_count++;
   endtask

   // Random double biased toward the interesting regions: integer boundaries
   // of every cell width, ties at one half, the single precision range and
   // its overflow and underflow edges, and the non-finite encodings.
   function automatic logic [63:0] pick_value();
      real         r;
      logic        sgn;
      logic [63:0] raw;
      sgn = 1'($urandom);
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1: pick_value = raw;
         2, 3: begin
            r = 2.0 ** $urandom_range(0, 65) + ($urandom_range(0, 8) - 4.0)
                + 0.5 * $urandom_range(0, 1);
            pick_value = $realtobits(sgn ? -r : r);
         end
         4, 5: pick_value = {sgn, 11'(1021 + $urandom_range(0, 68)), raw[51:0]};
         6: pick_value = {sgn, 11'(874 + $urandom_range(0, 280)), raw[51:0]};
         7: pick_value = {sgn, cves_pkg::SingleMaxDbl + 63'($urandom_range(0, 1 << 30))
                               - 63'(1 << 29)};
         8: begin
            if (raw[63])
               pick_value = {sgn, 11'h7ff, raw[0] ? 52'd0 : raw[51:0]};
            else
               pick_value = {sgn, 11'd0, raw[1] ? 52'd0 : raw[51:0]};
         end
         default: begin
            r = ($urandom_range(0, 4000) - 2000.0) / 4.0;
            pick_value = $realtobits(r);
         end
      endcase
   endfunction

   initial begin
      logic [63:0] basic_values[12];
      logic [63:0] single_values[7];
      logic [63:0] wide_values[5];
      request_count = 0;
      setting_count = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_value_in <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= cves_pkg::CSR_CELL_WIDTH;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset setting (one byte, unsigned integer): rounding ties, negatives,
      // both ends of the byte range, zeros of both signs and non-finite input.
      basic_values = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                       64'h3FE0_0000_0000_0000, 64'h3FF8_0000_0000_0000,
                       64'hBFE0_0000_0000_0000, 64'hBFD3_3333_3333_3333,
                       64'h406F_E000_0000_0000, 64'h406F_D000_0000_0000,
                       64'h7FF0_0000_0000_0000, 64'hFFF8_0000_0000_0001,
                       64'h000F_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF};
      foreach (basic_values[i]) send_value(basic_values[i], 1'b0);

      // Single precision cell: the largest single, values just past it in
      // both directions, a rounding tie and the subnormal underflow edge.
      set_cell(4'd4, 1'b0, 1'b1, 1'b1);
      single_values = '{64'h47EF_FFFF_E000_0000, 64'h47EF_FFFF_E000_0001,
                        64'hC7EF_FFFF_F000_0000, 64'h3FF0_0000_1000_0000,
                        64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0000,
                        64'h3810_0000_0000_0000};
      foreach (single_values[i]) send_value(single_values[i], 1'b0);

      // Full 64-bit signed cell: the upper saturation whose stored value
      // rounds up to 2^63, and the exact lower bound.
      set_cell(4'd8, 1'b1, 1'b0, 1'b0);
      wide_values = '{64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,
                      64'hC3E0_0000_0000_0001, 64'h43DF_FFFF_FFFF_FFFF,
                      64'hBFF8_0000_0000_0000};
      foreach (wide_values[i]) send_value(wide_values[i], 1'b0);

      // Random phases. The first settings cover the register extremes,
      // including widths that fold onto 1 and 8; the rest are random. Each
      // phase waits for the block to drain, which also exercises a sender
      // that holds off until every response is back.
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_cell(4'd0, 1'b1, 1'b0, 1'b1);
            1: set_cell(4'd15, 1'b0, 1'b0, 1'b1);
            2: set_cell(4'd4, 1'b1, 1'b1, 1'b0);
            3: set_cell(4'd8, 1'b0, 1'b1, 1'b1);
            4: set_cell(4'd9, 1'b1, 1'b0, 1'b0);
            default: set_cell(4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
         endcase
         // Phase 5 runs back to back with no gaps at all.
         repeat (45) send_value(pick_value(), phase != 5);
      end
      start <= 1'b0;

      wait (cells_waiting == 0);
      repeat (5) @(posedge clock);
      $display("Ran %0d requests over %0d cell settings; %0d responses checked.",
               request_count, setting_count + 1, cells_checked);
      if (mismatch_count == 0)
         $display("cell_value_encode_saturating_tb OK");
      else
         $display("cell_value_encode_saturating_tb NOT OK");
      $finish;
   end

endmodule
